/* hdl/tlw_pkg.sv */
// ----------------------------------------------------------------------------
// tlw_pkg
// Shared widths, codes and controller/datapath interface types for the
// topological wave leveler.
// ----------------------------------------------------------------------------
package tlw_pkg;

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int VERT_W   = 5;
  localparam int TASK_W   = 10;
  localparam int WAVE_W   = 5;
  localparam int STATUS_W = 2;
  localparam int VCOUNT_W = 6;
  localparam int TCOUNT_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // parameter defaults
  localparam int DEF_MAX_VERTICES    = 32;
  localparam int DEF_TASK_INDEX_BITS = 10;

  // request actions
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_EDGE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MAP   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CYCLE   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT   = 2'd1;

  // controller to datapath commands
  typedef struct packed {
    logic                take;      // apply an edit request
    logic                start;     // begin a run
    logic                check;     // validate one row, count in-degrees
    logic                seed;      // build wave 0
    logic                wstart;    // rewind the wave position
    logic                wread;     // read current wave list
    logic                wload;     // latch vertex, record schedule
    logic                walk;      // release one target
    logic                wend;      // swap wave lists
    logic                oread;     // read schedule entry
    logic                oload;     // load result register
    logic                ld_status; // load a status result
    logic [STATUS_W-1:0] st_code;
    logic                pop;       // result taken
  } tlw_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic n_zero;
    logic scan_last;
    logic seed_last;
    logic bad;
    logic cur_empty;
    logic mask_empty;
    logic wave_done;
    logic count_ok;
    logic out_last;
  } tlw_sts_t;

endpackage

/* hdl/tlw_ctrl.sv */
// ----------------------------------------------------------------------------
// tlw_ctrl
// Sequencing state machine: edit requests, validation scan, wave walk and
// result delivery.
// ----------------------------------------------------------------------------
module tlw_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [tlw_pkg::ACTION_W-1:0]  action,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  tlw_pkg::tlw_sts_t             sts,
  output tlw_pkg::tlw_cmd_t             cmd
);
  import tlw_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_SEED   = 4'd2;
  localparam logic [3:0] S_WSTART = 4'd3;
  localparam logic [3:0] S_WREAD  = 4'd4;
  localparam logic [3:0] S_WLOAD  = 4'd5;
  localparam logic [3:0] S_WALK   = 4'd6;
  localparam logic [3:0] S_WEND   = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_ORD    = 4'd9;
  localparam logic [3:0] S_OLOAD  = 4'd10;
  localparam logic [3:0] S_OWAIT  = 4'd11;

  logic [3:0] state, state_next;

  assign item_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.take = 1'b1;
          if (action == ACT_RUN) begin
            cmd.start = 1'b1;
            if (sts.n_zero) begin
              cmd.ld_status = 1'b1;
              cmd.st_code   = ST_EMPTY;
              state_next    = S_OWAIT;
            end else begin
              state_next = S_CHECK;
            end
          end
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.bad) begin
          cmd.ld_status = 1'b1;
          cmd.st_code   = ST_INVALID;
          state_next    = S_OWAIT;
        end else if (sts.scan_last) begin
          state_next = S_SEED;
        end
      end
      S_SEED: begin
        cmd.seed = 1'b1;
        if (sts.seed_last) state_next = S_WSTART;
      end
      S_WSTART: begin
        cmd.wstart = 1'b1;
        state_next = sts.cur_empty ? S_FIN : S_WREAD;
      end
      S_WREAD: begin
        cmd.wread  = 1'b1;
        state_next = S_WLOAD;
      end
      S_WLOAD: begin
        cmd.wload  = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (sts.mask_empty) begin
          state_next = sts.wave_done ? S_WEND : S_WREAD;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      S_WEND: begin
        cmd.wend   = 1'b1;
        state_next = S_WSTART;
      end
      S_FIN: begin
        if (sts.count_ok) begin
          state_next = S_ORD;
        end else begin
          cmd.ld_status = 1'b1;
          cmd.st_code   = ST_CYCLE;
          state_next    = S_OWAIT;
        end
      end
      S_ORD: begin
        cmd.oread  = 1'b1;
        state_next = S_OLOAD;
      end
      S_OLOAD: begin
        cmd.oload  = 1'b1;
        state_next = S_OWAIT;
      end
      S_OWAIT: begin
        if (result_valid && !result_stall) begin
          cmd.pop    = 1'b1;
          state_next = sts.out_last ? S_IDLE : S_ORD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/tlw_dp.sv */
// ----------------------------------------------------------------------------
// tlw_dp
// Datapath: adjacency matrix, task map, in-degree counters, ping-pong wave
// lists, schedule buffer and result register.
// ----------------------------------------------------------------------------
module tlw_dp #(
  parameter int MAX_VERTICES    = tlw_pkg::DEF_MAX_VERTICES,
  parameter int TASK_INDEX_BITS = tlw_pkg::DEF_TASK_INDEX_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [tlw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tlw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [tlw_pkg::ACTION_W-1:0]    action,
  input  logic [tlw_pkg::VERT_W-1:0]      source_vertex,
  input  logic [tlw_pkg::VERT_W-1:0]      target_vertex,
  input  logic [tlw_pkg::TASK_W-1:0]      task_number,
  input  tlw_pkg::tlw_cmd_t               cmd,
  output tlw_pkg::tlw_sts_t               sts,
  output logic                            result_valid,
  output logic [tlw_pkg::TASK_W-1:0]      task_id,
  output logic [tlw_pkg::WAVE_W-1:0]      wave_number,
  output logic [tlw_pkg::STATUS_W-1:0]    status,
  output logic                            last
);
  import tlw_pkg::*;

  localparam int N  = MAX_VERTICES;
  localparam int TB = TASK_INDEX_BITS;
  localparam int VW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int SW = WAVE_W + TB;

  // configuration
  logic [VCOUNT_W-1:0] num_vertices;
  logic [TCOUNT_W-1:0] num_tasks;

  // graph store
  logic [N-1:0]  adj [N];
  logic [TB-1:0] vmap [N];
  logic [CW-1:0] deg [N];

  // run control
  logic [CW-1:0]     cnt, cur_len, next_len, pos, total, optr;
  logic              bank;
  logic [WAVE_W-1:0] wave;
  logic [N-1:0]      mask;

  // list and schedule memories
  logic [VW-1:0] list_a [N];
  logic [VW-1:0] list_b [N];
  logic [SW-1:0] sched [N];
  logic [VW-1:0] rd_a, rd_b;
  logic [SW-1:0] rd_s;

  logic [CW-1:0] n;
  logic [N-1:0]  nmask, nz, row;
  logic [VW-1:0] cur_v, pick;
  logic          v_in;
  logic          wr_en, wr_bank;
  logic [VW-1:0] wr_addr, wr_data;

  // clipped vertex count
  always_comb begin
    if (32'(num_vertices) > 32'(N)) n = CW'(N);
    else n = CW'(num_vertices);
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      nmask[k] = (k < int'(n));
      nz[k]    = (deg[k] != '0);
    end
  end

  assign row   = adj[cnt[VW-1:0]];
  assign v_in  = (cnt < n);
  assign cur_v = bank ? rd_b : rd_a;

  // lowest pending target
  always_comb begin
    pick = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (mask[k]) pick = VW'(k);
    end
  end

  // status towards the controller
  always_comb begin
    sts            = '0;
    sts.n_zero     = (n == '0);
    sts.scan_last  = (cnt == CW'(N - 1));
    sts.seed_last  = (cnt == n - CW'(1));
    if (v_in) begin
      sts.bad = (|(row & ~nmask)) || (32'(vmap[cnt[VW-1:0]]) >= 32'(num_tasks));
    end else begin
      sts.bad = |row;
    end
    sts.cur_empty  = (cur_len == '0);
    sts.mask_empty = (mask == '0);
    sts.wave_done  = (pos == cur_len);
    sts.count_ok   = (total == n);
    sts.out_last   = last;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= '0;
      num_tasks    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VERTEX_COUNT: num_vertices <= cfg_data[VCOUNT_W-1:0];
        REG_TASK_COUNT:   num_tasks    <= cfg_data[TCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // adjacency and task map edits
  always_ff @(posedge clk) begin
    if (rst || (cmd.take && action == ACT_CLEAR)) begin
      for (int k = 0; k < N; k++) begin
        adj[k]  <= '0;
        vmap[k] <= '0;
      end
    end else if (cmd.take && action == ACT_EDGE) begin
      if (32'(source_vertex) < 32'(N) && 32'(target_vertex) < 32'(N))
        adj[VW'(source_vertex)][VW'(target_vertex)] <= 1'b1;
    end else if (cmd.take && action == ACT_MAP) begin
      if (32'(source_vertex) < 32'(N))
        vmap[VW'(source_vertex)] <= TB'(task_number);
    end
  end

  // in-degree counters
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      for (int k = 0; k < N; k++) deg[k] <= '0;
    end else if (cmd.check && v_in) begin
      for (int k = 0; k < N; k++) begin
        if (row[k] && nmask[k]) deg[k] <= deg[k] + CW'(1);
      end
    end else if (cmd.walk) begin
      deg[pick] <= deg[pick] - CW'(1);
    end
  end

  // list write select
  always_comb begin
    wr_en   = 1'b0;
    wr_bank = bank;
    wr_addr = cur_len[VW-1:0];
    wr_data = cnt[VW-1:0];
    if (cmd.seed) begin
      wr_en = v_in && (deg[cnt[VW-1:0]] == '0);
    end else if (cmd.walk) begin
      wr_en   = (deg[pick] == CW'(1));
      wr_bank = ~bank;
      wr_addr = next_len[VW-1:0];
      wr_data = pick;
    end
  end

  // wave list memories
  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) list_a[wr_addr] <= wr_data;
    if (wr_en && wr_bank)  list_b[wr_addr] <= wr_data;
    rd_a <= list_a[pos[VW-1:0]];
    rd_b <= list_b[pos[VW-1:0]];
  end

  // schedule buffer
  always_ff @(posedge clk) begin
    if (cmd.wload) sched[total[VW-1:0]] <= {wave, vmap[cur_v]};
    rd_s <= sched[optr[VW-1:0]];
  end

  // run counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      cur_len  <= '0;
      next_len <= '0;
      pos      <= '0;
      total    <= '0;
      optr     <= '0;
      bank     <= 1'b0;
      wave     <= '0;
      mask     <= '0;
    end else begin
      if (cmd.start) begin
        cnt      <= '0;
        cur_len  <= '0;
        next_len <= '0;
        total    <= '0;
        optr     <= '0;
        bank     <= 1'b0;
        wave     <= '0;
      end
      if (cmd.check) cnt <= sts.scan_last ? '0 : cnt + CW'(1);
      if (cmd.seed) begin
        cnt <= cnt + CW'(1);
        if (wr_en) cur_len <= cur_len + CW'(1);
      end
      if (cmd.wstart) pos <= '0;
      if (cmd.wload) begin
        total <= total + CW'(1);
        pos   <= pos + CW'(1);
        mask  <= adj[cur_v] & nmask & nz;
      end
      if (cmd.walk) begin
        mask[pick] <= 1'b0;
        if (wr_en) next_len <= next_len + CW'(1);
      end
      if (cmd.wend) begin
        cur_len  <= next_len;
        next_len <= '0;
        bank     <= ~bank;
        wave     <= wave + WAVE_W'(1);
      end
      if (cmd.pop) optr <= optr + CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.ld_status || cmd.oload) begin
      result_valid <= 1'b1;
    end else if (cmd.pop) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_status) begin
      task_id     <= '0;
      wave_number <= '0;
      status      <= cmd.st_code;
      last        <= 1'b1;
    end else if (cmd.oload) begin
      task_id     <= TASK_W'(rd_s[TB-1:0]);
      wave_number <= rd_s[SW-1:TB];
      status      <= ST_OK;
      last        <= (optr == n - CW'(1));
    end
  end

endmodule

/* hdl/topological_wave_leveler.sv */
// ----------------------------------------------------------------------------
// topological_wave_leveler
// Levels a dependency graph into execution waves (Kahn's algorithm by levels).
// ----------------------------------------------------------------------------
// Clear, add-edge and map requests do not stall the input. A run request
// holds the input stalled until its last result is taken: accept, validate
// every vertex slot (MAX_VERTICES), seed, then per wave vertex a read, a load
// and one release step per outgoing edge, a list swap per wave, closing the
// walk, and per result a read and a load (a status result is loaded
// directly) plus any output stall. The run time is set by the single-target
// release step walking the adjacency matrix.
module topological_wave_leveler #(
  parameter int MAX_VERTICES    = tlw_pkg::DEF_MAX_VERTICES,
  parameter int TASK_INDEX_BITS = tlw_pkg::DEF_TASK_INDEX_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tlw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [tlw_pkg::ACTION_W-1:0]    action,
  input  logic [tlw_pkg::VERT_W-1:0]      source_vertex,
  input  logic [tlw_pkg::VERT_W-1:0]      target_vertex,
  input  logic [tlw_pkg::TASK_W-1:0]      task_number,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [tlw_pkg::TASK_W-1:0]      task_id,
  output logic [tlw_pkg::WAVE_W-1:0]      wave_number,
  output logic [tlw_pkg::STATUS_W-1:0]    status,
  output logic                            last
);
  import tlw_pkg::*;

  tlw_cmd_t cmd;
  tlw_sts_t sts;

  // registers are always writable
  assign cfg_ready = 1'b1;

  tlw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  tlw_dp #(
    .MAX_VERTICES    (MAX_VERTICES),
    .TASK_INDEX_BITS (TASK_INDEX_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .source_vertex (source_vertex),
    .target_vertex (target_vertex),
    .task_number   (task_number),
    .cmd           (cmd),
    .sts           (sts),
    .result_valid  (result_valid),
    .task_id       (task_id),
    .wave_number   (wave_number),
    .status        (status),
    .last          (last)
  );

endmodule
